// ===== hw/rtl/mlfq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared constants, queue codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mlfq_pkg;

	localparam int MAX_JOBS = 16;
	localparam int JW       = 4;                      // job id field width
	localparam int IW       = $clog2(MAX_JOBS);       // job table index width
	localparam int CW       = $clog2(MAX_JOBS + 1);   // queue count width
	localparam int NQ       = 5;
	localparam int QW       = 3;

	// queue codes; the three level codes equal the level numbers
	localparam logic [QW-1:0] Q_L0   = 3'd0;
	localparam logic [QW-1:0] Q_L1   = 3'd1;
	localparam logic [QW-1:0] Q_L2   = 3'd2;
	localparam logic [QW-1:0] Q_IO   = 3'd3;
	localparam logic [QW-1:0] Q_PEND = 3'd4;

	// job selection
	localparam logic [1:0] JSEL_IN   = 2'd0;
	localparam logic [1:0] JSEL_RUN  = 2'd1;
	localparam logic [1:0] JSEL_HEAD = 2'd2;

	// job table operations
	localparam logic [2:0] JOP_NONE   = 3'd0;
	localparam logic [2:0] JOP_ARRIVE = 3'd1;
	localparam logic [2:0] JOP_LVL0   = 3'd2;
	localparam logic [2:0] JOP_SLICE0 = 3'd3;
	localparam logic [2:0] JOP_RUN    = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_SLICE0 = 2'd0;
	localparam logic [1:0] REG_SLICE1 = 2'd1;
	localparam logic [1:0] REG_SLICE2 = 2'd2;
	localparam logic [1:0] REG_BOOST  = 2'd3;

	typedef struct packed {
		logic          load_item;
		logic          res_clr;
		logic          res_rej;
		logic          res_run;
		logic [NQ-1:0] pop;
		logic          push;
		logic [QW-1:0] push_q;
		logic [QW-1:0] head_q;
		logic [1:0]    jsel;
		logic [2:0]    jop;
		logic          run_set;
		logic          run_clr;
		logic          tick;
		logic          boost_clr;
		logic          out_load;
	} cmd_t;

	typedef struct packed {
		logic          present;
		logic          in_range;
		logic [1:0]    lvl;
		logic [1:0]    dem_lvl;
		logic          reached;
		logic          done_next;
		logic          reached_next;
		logic          io_req;
		logic [15:0]   mask;
		logic          run_valid;
		logic          boost_due;
		logic [NQ-1:0] nonempty;
		logic [CW-1:0] io_cnt;
		logic          out_busy;
	} status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mlfq_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_scheduler
// Three-level feedback-queue scheduler with an I/O wait queue.
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_*       in   tuser: operation; tdata: job_id, service_time, io_want,
//                io_done_mask
// m_*       out  tdata: running_valid, running_job, completed, finish_time,
//                all_idle, rejected
// apb       in   slice_level0..2 at 0x0/0x4/0x8, boost_interval at 0xC
//
// One item at a time. An arrive passes S_ARR and S_FIN; a tick passes S_BCHK,
// S_PEND, S_IO, S_REQ, S_SEL, S_RUN and S_FIN, and when a boost is due also
// S_B1, S_B2 and S_BRUN after S_BCHK: the sequencer moves one job per cycle.
// A result waits in the output register; the next item is taken meanwhile,
// and its result holds the sequencer in its last state until the first is gone.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
module mlfq_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // job_id, service_time, io_want, io_done_mask
	input  wire logic [0:0]  s_tuser,  // operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // running_valid, running_job, completed,
	                                   // finish_time, all_idle, rejected
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import mlfq_pkg::*;

	cmd_t    cmd;
	status_t st;

	assign pready = 1'b1;

	mlfq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.in_op   (s_tuser[0]),
		.st      (st),
		.cmd     (cmd)
	);

	mlfq_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.st      (st),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/mlfq_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_fifo
// Circular job-id queue with combinational head; push and pop may coincide.
// ----------------------------------------------------------------------------
module mlfq_fifo (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire logic                    pop,
	input  wire logic [mlfq_pkg::JW-1:0] din,
	output logic [mlfq_pkg::JW-1:0]      head,
	output logic [mlfq_pkg::CW-1:0]      count
);
	import mlfq_pkg::*;

	logic [JW-1:0] mem_q [MAX_JOBS];
	logic [IW-1:0] rd_q, wr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] p);
		return (p == IW'(MAX_JOBS - 1)) ? '0 : p + 1'b1;
	endfunction

	assign do_pop  = pop && (cnt_q != '0);
	assign do_push = push && ((cnt_q != CW'(MAX_JOBS)) || do_pop);
	assign head    = mem_q[rd_q];
	assign count   = cnt_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_pop) begin
				rd_q <= nxt(rd_q);
			end
			if (do_push) begin
				wr_q <= nxt(wr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mlfq_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_dp
// Datapath: queues, job table, run slot, counters, config registers, output.
// ----------------------------------------------------------------------------
module mlfq_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mlfq_pkg::cmd_t    cmd,
	output mlfq_pkg::status_t      st,
	input  wire logic [39:0]       s_tdata,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [39:0]            m_tdata,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata
);
	import mlfq_pkg::*;

	// config
	logic [7:0]  slice0_q, slice1_q, slice2_q;
	logic [15:0] boost_iv_q;

	// item
	logic [JW-1:0] item_id_q;
	logic [15:0]   item_svc_q;
	logic          item_io_q;
	logic [15:0]   item_mask_q;

	// queues
	logic [JW-1:0] heads [NQ];
	logic [CW-1:0] cnts  [NQ];
	logic [JW-1:0] head_sel, jidx;
	logic [IW-1:0] ji;

	// job table
	logic [1:0]  lvl_q  [MAX_JOBS];
	logic [7:0]  slc_q  [MAX_JOBS];
	logic [15:0] rem_q  [MAX_JOBS];
	logic [MAX_JOBS-1:0] present_q;

	logic          run_valid_q;
	logic [JW-1:0] run_id_q;
	logic [31:0]   clk_cnt_q;
	logic [15:0]   boost_cnt_q;

	logic          res_rej_q, res_ran_q, res_done_q;
	logic [JW-1:0] res_id_q;
	logic [31:0]   res_t_q;

	logic [1:0]  cur_lvl, dem_lvl;
	logic [7:0]  cur_slc, slc_next, lim;
	logic [15:0] cur_rem, rem_next;
	logic        done_next, reached_next, idle;
	logic [NQ-1:0] nonempty;

	genvar q;
	generate
		for (q = 0; q < NQ; q++) begin : g_q
			mlfq_fifo u_fifo (
				.clk   (clk),
				.arst_n(arst_n),
				.push  (cmd.push && (cmd.push_q == QW'(q))),
				.pop   (cmd.pop[q]),
				.din   (jidx),
				.head  (heads[q]),
				.count (cnts[q])
			);
			assign nonempty[q] = (cnts[q] != '0);
		end
	endgenerate

	always_comb begin
		head_sel = heads[0];
		for (int k = 1; k < NQ; k++) begin
			if (cmd.head_q == QW'(k)) begin
				head_sel = heads[k];
			end
		end
	end

	always_comb begin
		case (cmd.jsel)
			JSEL_IN:   jidx = item_id_q;
			JSEL_RUN:  jidx = run_id_q;
			JSEL_HEAD: jidx = head_sel;
			default:   jidx = item_id_q;
		endcase
	end

	assign ji      = IW'(jidx);
	assign cur_lvl = lvl_q[ji];
	assign cur_slc = slc_q[ji];
	assign cur_rem = rem_q[ji];

	always_comb begin
		case (cur_lvl)
			2'd0:    lim = slice0_q;
			2'd1:    lim = slice1_q;
			default: lim = slice2_q;
		endcase
	end

	// zero remaining behaves as one unit
	assign rem_next     = (cur_rem != '0) ? cur_rem - 1'b1 : '0;
	assign slc_next     = (cur_slc != 8'hFF) ? cur_slc + 1'b1 : cur_slc;
	assign done_next    = (rem_next == '0);
	assign reached_next = (slc_next >= lim);
	assign dem_lvl      = (cur_lvl < 2'd2) ? cur_lvl + 1'b1 : 2'd2;
	assign idle         = !run_valid_q && (nonempty == '0);

	always_comb begin
		st.present      = present_q[ji];
		st.in_range     = (32'(item_id_q) < MAX_JOBS);
		st.lvl          = cur_lvl;
		st.dem_lvl      = dem_lvl;
		st.reached      = (cur_slc >= lim);
		st.done_next    = done_next;
		st.reached_next = reached_next;
		st.io_req       = item_io_q;
		st.mask         = item_mask_q;
		st.run_valid    = run_valid_q;
		st.boost_due    = (boost_cnt_q >= boost_iv_q);
		st.nonempty     = nonempty;
		st.io_cnt       = cnts[Q_IO];
		st.out_busy     = m_tvalid && !m_tready;
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_id_q   <= s_tdata[3:0];
			item_svc_q  <= s_tdata[19:4];
			item_io_q   <= s_tdata[20];
			item_mask_q <= s_tdata[36:21];
		end
		case (cmd.jop)
			JOP_ARRIVE: begin
				rem_q[ji] <= item_svc_q;
				lvl_q[ji] <= 2'd0;
				slc_q[ji] <= '0;
			end
			JOP_LVL0: begin
				lvl_q[ji] <= 2'd0;
				slc_q[ji] <= '0;
			end
			JOP_SLICE0: begin
				slc_q[ji] <= '0;
			end
			JOP_RUN: begin
				rem_q[ji] <= rem_next;
				if (!done_next && !item_io_q && reached_next) begin
					lvl_q[ji] <= dem_lvl;
					slc_q[ji] <= '0;
				end else begin
					slc_q[ji] <= slc_next;
				end
			end
			default: ;
		endcase
		if (cmd.res_clr) begin
			res_rej_q  <= 1'b0;
			res_ran_q  <= 1'b0;
			res_done_q <= 1'b0;
			res_id_q   <= '0;
			res_t_q    <= '0;
		end else if (cmd.res_rej) begin
			res_rej_q <= 1'b1;
		end else if (cmd.res_run) begin
			res_ran_q  <= 1'b1;
			res_id_q   <= run_id_q;
			res_done_q <= done_next;
			res_t_q    <= done_next ? clk_cnt_q + 1'b1 : '0;
		end
		if (cmd.out_load) begin
			m_tdata <= {res_rej_q, idle, res_t_q, res_done_q, res_id_q, res_ran_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= '0;
			run_valid_q <= 1'b0;
			run_id_q    <= '0;
			clk_cnt_q   <= '0;
			boost_cnt_q <= '0;
			m_tvalid    <= 1'b0;
			slice0_q    <= 8'd1;
			slice1_q    <= 8'd2;
			slice2_q    <= 8'd4;
			boost_iv_q  <= 16'd50;
		end else begin
			if (cmd.jop == JOP_ARRIVE) begin
				present_q[ji] <= 1'b1;
			end else if (cmd.jop == JOP_RUN && done_next) begin
				present_q[ji] <= 1'b0;
			end
			if (cmd.run_set) begin
				run_valid_q <= 1'b1;
				run_id_q    <= head_sel;
			end else if (cmd.run_clr) begin
				run_valid_q <= 1'b0;
			end
			if (cmd.tick) begin
				clk_cnt_q <= clk_cnt_q + 1'b1;
				if (boost_cnt_q != 16'hFFFF) begin
					boost_cnt_q <= boost_cnt_q + 1'b1;
				end
			end else if (cmd.boost_clr) begin
				boost_cnt_q <= '0;
			end
			if (cmd.out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					REG_SLICE0: slice0_q   <= pwdata[7:0];
					REG_SLICE1: slice1_q   <= pwdata[7:0];
					REG_SLICE2: slice2_q   <= pwdata[7:0];
					REG_BOOST:  boost_iv_q <= pwdata[15:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SLICE0: prdata = {24'd0, slice0_q};
			REG_SLICE1: prdata = {24'd0, slice1_q};
			REG_SLICE2: prdata = {24'd0, slice2_q};
			REG_BOOST:  prdata = {16'd0, boost_iv_q};
			default:    prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mlfq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer: queues an arrive; a tick: boost, admit, I/O release, pick, run.
// ----------------------------------------------------------------------------
module mlfq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic              in_op,
	input  wire mlfq_pkg::status_t st,
	output mlfq_pkg::cmd_t         cmd
);
	import mlfq_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ARR  = 4'd1;
	localparam logic [3:0] S_BCHK = 4'd2;
	localparam logic [3:0] S_B1   = 4'd3;
	localparam logic [3:0] S_B2   = 4'd4;
	localparam logic [3:0] S_BRUN = 4'd5;
	localparam logic [3:0] S_PEND = 4'd6;
	localparam logic [3:0] S_IO   = 4'd7;
	localparam logic [3:0] S_REQ  = 4'd8;
	localparam logic [3:0] S_SEL  = 4'd9;
	localparam logic [3:0] S_RUN  = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] io_left_q, pos_q;
	logic          io_init, io_step;
	logic [15:0]   mask_sh;

	assign s_tready = (state_q == S_IDLE);
	assign mask_sh  = st.mask >> pos_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		io_init  = 1'b0;
		io_step  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					cmd.res_clr   = 1'b1;
					state_d       = in_op ? S_BCHK : S_ARR;
				end
			end
			S_ARR: begin
				cmd.jsel = JSEL_IN;
				if (!st.in_range || st.present) begin
					cmd.res_rej = 1'b1;
				end else begin
					cmd.jop    = JOP_ARRIVE;
					cmd.push   = 1'b1;
					cmd.push_q = Q_PEND;
				end
				state_d = S_FIN;
			end
			S_BCHK: begin
				state_d = st.boost_due ? S_B1 : S_PEND;
			end
			S_B1, S_B2: begin
				cmd.head_q = (state_q == S_B1) ? Q_L1 : Q_L2;
				cmd.jsel   = JSEL_HEAD;
				if (st.nonempty[cmd.head_q]) begin
					cmd.pop[cmd.head_q] = 1'b1;
					cmd.jop    = JOP_LVL0;
					cmd.push   = 1'b1;
					cmd.push_q = Q_L0;
				end else begin
					state_d = (state_q == S_B1) ? S_B2 : S_BRUN;
				end
			end
			S_BRUN: begin
				cmd.jsel      = JSEL_RUN;
				cmd.boost_clr = 1'b1;
				if (st.run_valid && st.lvl != 2'd0) begin
					cmd.jop = JOP_LVL0;
				end
				state_d = S_PEND;
			end
			S_PEND: begin
				cmd.head_q = Q_PEND;
				cmd.jsel   = JSEL_HEAD;
				if (st.nonempty[Q_PEND]) begin
					cmd.pop[Q_PEND] = 1'b1;
					cmd.jop    = JOP_LVL0;
					cmd.push   = 1'b1;
					cmd.push_q = Q_L0;
				end else begin
					io_init = 1'b1;
					state_d = S_IO;
				end
			end
			S_IO: begin
				// one I/O entry per cycle; kept entries rotate to the tail
				cmd.head_q = Q_IO;
				cmd.jsel   = JSEL_HEAD;
				if (io_left_q != '0) begin
					io_step       = 1'b1;
					cmd.pop[Q_IO] = 1'b1;
					cmd.push      = 1'b1;
					if (mask_sh[0]) begin
						cmd.jop    = JOP_SLICE0;
						cmd.push_q = {1'b0, st.lvl};
					end else begin
						cmd.push_q = Q_IO;
					end
				end else begin
					state_d = S_REQ;
				end
			end
			S_REQ: begin
				cmd.jsel = JSEL_RUN;
				if (st.run_valid && st.reached) begin
					cmd.push    = 1'b1;
					cmd.push_q  = {1'b0, st.lvl};
					cmd.run_clr = 1'b1;
				end
				state_d = S_SEL;
			end
			S_SEL: begin
				if (!st.run_valid && (st.nonempty[2:0] != '0)) begin
					if (st.nonempty[Q_L0]) begin
						cmd.head_q = Q_L0;
					end else if (st.nonempty[Q_L1]) begin
						cmd.head_q = Q_L1;
					end else begin
						cmd.head_q = Q_L2;
					end
					cmd.pop[cmd.head_q] = 1'b1;
					cmd.run_set = 1'b1;
				end
				state_d = S_RUN;
			end
			S_RUN: begin
				cmd.jsel = JSEL_RUN;
				cmd.tick = 1'b1;
				if (st.run_valid) begin
					cmd.jop     = JOP_RUN;
					cmd.res_run = 1'b1;
					if (st.done_next) begin
						cmd.run_clr = 1'b1;
					end else if (st.io_req) begin
						cmd.push    = 1'b1;
						cmd.push_q  = Q_IO;
						cmd.run_clr = 1'b1;
					end else if (st.reached_next) begin
						cmd.push    = 1'b1;
						cmd.push_q  = {1'b0, st.dem_lvl};
						cmd.run_clr = 1'b1;
					end
				end
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			io_left_q <= '0;
			pos_q     <= '0;
		end else begin
			state_q <= state_d;
			if (io_init) begin
				io_left_q <= st.io_cnt;
				pos_q     <= '0;
			end else if (io_step) begin
				io_left_q <= io_left_q - 1'b1;
				pos_q     <= pos_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire
